// ===== hw/rtl/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Cartridge bank controller package
// Shared word types, codes and constants of the cartridge bank controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

    localparam int MAX_ROM_BANKS     = 64;
    localparam int MAX_RAM_BANKS     = 16;
    localparam int RAM_BANK_BYTES    = 8192;
    localparam int ROM_BANK_W        = 6;
    localparam int RAM_BANK_W        = 4;
    localparam int ROM_ADDR_W        = 20;
    localparam int CFG_DATA_W        = 8;

    localparam logic [7:0] RAM_ENABLE_KEY = 8'h0A;
    localparam logic [7:0] OPEN_BUS_BYTE  = 8'hFF;

    typedef enum logic [1:0] {
        MAPPER_ROM_ONLY = 2'd0,
        MAPPER_MBC1     = 2'd1,
        MAPPER_MBC2     = 2'd2,
        MAPPER_MBC3     = 2'd3
    } t_mapper;

    typedef enum logic [1:0] {
        CFG_MAPPER_KIND    = 2'd0,
        CFG_ROM_BANK_COUNT = 2'd1,
        CFG_RAM_BANK_COUNT = 2'd2,
        CFG_UNUSED         = 2'd3
    } t_cfg_index;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_operation;

    typedef enum logic [1:0] {
        REGION_ROM  = 2'd0,
        REGION_RAM  = 2'd1,
        REGION_NONE = 2'd2
    } t_region;

    typedef struct packed {
        logic        operation;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in_word;

    typedef struct packed {
        logic [1:0]            region;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic [7:0]            read_data;
    } t_out_word;

    // Sets every bit below the highest set bit.
    function automatic logic [6:0] smear(input logic [6:0] v);
        logic [6:0] s;
        s = v;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        return s;
    endfunction

endpackage

// ===== hw/rtl/cartridge_bank_controller_core.sv =====
// ----------------------------------------------------------------------------
// Cartridge bank controller core
// Maps CPU bus accesses onto banked ROM addresses and banked cartridge RAM.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  word
//  in        sink       i_in_valid / o_in_stall    i_in_word  (t_in_word)
//  out       source     o_out_valid / i_out_stall  o_out_word (t_out_word)
//  cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One word is accepted per cycle while o_in_stall is low; each result passes
// through the cartridge RAM read stage and then the output register.
// Reset sets ROM bank 1, RAM bank 0; RAM is not cleared, so no clearing pass.
// A stalled output holds the result register, and the RAM stage then stalls
// the input; the RAM stage and output register let one word wait per stage.
module cartridge_bank_controller_core #(
    parameter int MAX_RAM_BANKS = cbc_pkg::MAX_RAM_BANKS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  cbc_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output cbc_pkg::t_out_word             o_out_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RamDepth = MAX_RAM_BANKS * cbc_pkg::RAM_BANK_BYTES;
    localparam int RamAddrW = $clog2(RamDepth);

    logic [1:0]                      r_kind;
    logic [6:0]                      r_rom_count;
    logic [4:0]                      r_ram_count;
    logic                            r_ram_enabled;
    logic [cbc_pkg::ROM_BANK_W-1:0]  r_rom_bank;
    logic [cbc_pkg::RAM_BANK_W-1:0]  r_ram_bank;
    logic                            n_ram_enabled;
    logic [cbc_pkg::ROM_BANK_W-1:0]  n_rom_bank;
    logic [cbc_pkg::RAM_BANK_W-1:0]  n_ram_bank;

    logic                            r_s1_valid;
    logic [1:0]                      r_s1_region;
    logic [cbc_pkg::ROM_ADDR_W-1:0]  r_s1_rom_address;
    logic                            r_s1_ram_read;
    logic [1:0]                      n_s1_region;
    logic [cbc_pkg::ROM_ADDR_W-1:0]  n_s1_rom_address;
    logic                            n_s1_ram_read;

    logic                            r_out_valid;
    cbc_pkg::t_out_word              r_out_word;

    logic                            in_acc;
    logic                            out_free;
    logic                            s1_move;
    logic                            is_write;
    logic                            in_ram_window;
    logic                            ram_access;
    logic                            is_banked_mapper;
    logic [16:0]                     ram_index_full;
    logic [RamAddrW-1:0]             ram_addr;
    logic [7:0]                      ram_rdata;
    logic [6:0]                      rom_sel;
    logic [6:0]                      rom_n;
    logic [5:0]                      rom_mask;
    logic [4:0]                      ram_n;
    logic [6:0]                      ram_mask;
    logic [cbc_pkg::RAM_BANK_W-1:0]  ram_wrap;

    assign o_cfg_ready = 1'b1;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign is_write         = (i_in_word.operation == cbc_pkg::OP_WRITE);
    assign in_ram_window    = (i_in_word.address[15:13] == 3'b101);
    assign ram_access       = in_acc && in_ram_window && r_ram_enabled;
    assign is_banked_mapper = (r_kind == cbc_pkg::MAPPER_MBC1) ||
                              (r_kind == cbc_pkg::MAPPER_MBC3);

    assign ram_index_full = {r_ram_bank, i_in_word.address[12:0]};
    assign ram_addr       = ram_index_full[RamAddrW-1:0];

    cbc_ram #(
        .WIDTH(8),
        .DEPTH(RamDepth)
    ) u_cart_ram (
        .i_clk  (i_clk),
        .i_en   (ram_access),
        .i_we   (is_write),
        .i_addr (ram_addr),
        .i_wdata(i_in_word.write_data),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        rom_n = r_rom_count;
        if (rom_n == 7'd0 || rom_n > 7'(cbc_pkg::MAX_ROM_BANKS)) begin
            rom_n = 7'(cbc_pkg::MAX_ROM_BANKS);
        end
        rom_mask = 6'(cbc_pkg::smear(rom_n - 7'd1));

        ram_n = r_ram_count;
        if (ram_n > 5'(MAX_RAM_BANKS)) begin
            ram_n = 5'(MAX_RAM_BANKS);
        end
        ram_mask = cbc_pkg::smear({2'b00, ram_n - 5'd1});
        ram_wrap = {1'b0, i_in_word.write_data[2:0] & ram_mask[2:0]};
        for (int k = 0; k < 8; k++) begin
            if ({1'b0, ram_wrap} >= 5'(MAX_RAM_BANKS)) begin
                ram_wrap = 4'({1'b0, ram_wrap} - 5'(MAX_RAM_BANKS));
            end
        end

        if (r_kind == cbc_pkg::MAPPER_MBC1) begin
            rom_sel = {2'b00, i_in_word.write_data[4:0]};
        end else begin
            rom_sel = i_in_word.write_data[6:0];
        end

        n_ram_enabled = r_ram_enabled;
        n_rom_bank    = r_rom_bank;
        n_ram_bank    = r_ram_bank;
        if (in_acc && is_write && !i_in_word.address[15] && is_banked_mapper) begin
            if (i_in_word.address[15:13] == 3'b000) begin
                n_ram_enabled = (i_in_word.write_data == cbc_pkg::RAM_ENABLE_KEY);
            end else if (i_in_word.address[15:14] == 2'b00) begin
                if (rom_sel == 7'd0) begin
                    n_rom_bank = 6'd1;
                end else begin
                    n_rom_bank = rom_sel[5:0] & rom_mask;
                end
            end else if (r_kind == cbc_pkg::MAPPER_MBC3 &&
                         i_in_word.address[15:13] == 3'b010) begin
                if (i_in_word.write_data <= 8'h07 && r_ram_count != 5'd0) begin
                    n_ram_bank = ram_wrap;
                end
            end
        end

        n_s1_region      = cbc_pkg::REGION_NONE;
        n_s1_rom_address = '0;
        n_s1_ram_read    = 1'b0;
        if (!i_in_word.address[15]) begin
            if (is_write) begin
                n_s1_region = cbc_pkg::REGION_RAM;
            end else begin
                n_s1_region = cbc_pkg::REGION_ROM;
                if (!i_in_word.address[14]) begin
                    n_s1_rom_address = {6'd0, i_in_word.address[13:0]};
                end else begin
                    n_s1_rom_address = {r_rom_bank, i_in_word.address[13:0]};
                end
            end
        end else if (in_ram_window) begin
            n_s1_region   = cbc_pkg::REGION_RAM;
            n_s1_ram_read = r_ram_enabled && !is_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind        <= cbc_pkg::MAPPER_ROM_ONLY;
            r_rom_count   <= 7'd2;
            r_ram_count   <= 5'd1;
            r_ram_enabled <= 1'b0;
            r_rom_bank    <= 6'd1;
            r_ram_bank    <= '0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    cbc_pkg::CFG_MAPPER_KIND:    r_kind      <= i_cfg_data[1:0];
                    cbc_pkg::CFG_ROM_BANK_COUNT: r_rom_count <= i_cfg_data[6:0];
                    cbc_pkg::CFG_RAM_BANK_COUNT: r_ram_count <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            r_ram_enabled <= n_ram_enabled;
            r_rom_bank    <= n_rom_bank;
            r_ram_bank    <= n_ram_bank;
            if (!o_in_stall) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_region      <= n_s1_region;
            r_s1_rom_address <= n_s1_rom_address;
            r_s1_ram_read    <= n_s1_ram_read;
        end
        if (s1_move) begin
            r_out_word.region      <= r_s1_region;
            r_out_word.rom_address <= r_s1_rom_address;
            r_out_word.read_data   <= r_s1_ram_read ? ram_rdata : cbc_pkg::OPEN_BUS_BYTE;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== hw/rtl/cbc_ram.sv =====
// ----------------------------------------------------------------------------
// Cartridge bank controller RAM
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module cbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule
